FILE: rtl/trickle_interval_timer_unit_macros.svh
// assertion macros for the trickle interval timer
// used by the top level only; expects clk and rst_n in scope
`ifndef TRICKLE_INTERVAL_TIMER_UNIT_MACROS_SVH
`define TRICKLE_INTERVAL_TIMER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TRK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trickle timer check failed");

// next-cycle implication, disabled in reset
`define TRK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trickle timer check failed");

`endif

FILE: rtl/trk_pkg.sv
// shared types and codes for the trickle interval timer
// no dependencies
package trk_pkg;

  localparam int RND_W = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_SENT  = 2'd2;

  localparam logic CFG_MIN_INTERVAL  = 1'b0;
  localparam logic CFG_MAX_DOUBLINGS = 1'b1;

  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [RND_W-1:0] divisor;
  } trk_div_req_t;

  typedef struct packed {
    logic             done;
    logic [RND_W-1:0] rem;
  } trk_div_sts_t;

endpackage

FILE: rtl/trk_mod_serial.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on trk_pkg
module trk_mod_serial
  import trk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  trk_div_req_t req,
  output trk_div_sts_t sts
);

  localparam int CNT_W = $clog2(RND_W);

  logic [RND_W-1:0] q_r, q_nxt;
  logic [RND_W-1:0] r_r, r_nxt;
  logic [RND_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [RND_W:0]   r_sh;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    r_sh     = {r_r, q_r[RND_W-1]};
    if (req.start) begin
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = CNT_W'(RND_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract of the shifted partial remainder
      if (r_sh >= {1'b0, d_r}) begin
        r_nxt = RND_W'(r_sh - {1'b0, d_r});
      end else begin
        r_nxt = r_sh[RND_W-1:0];
      end
      q_nxt   = {q_r[RND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.rem  = r_r;

endmodule

FILE: rtl/trickle_interval_timer_unit.sv
// Trickle interval timer (no redundancy counter): tick, reset/start and
// sent-mark items, one result per item. Uses trk_pkg and trk_mod_serial.
//
// Flow: an item is taken only while the unit is idle. The next item can
// follow once the result is loaded, when the result side is not stalled.
// A sent mark, an unused code or a tick before start goes to output.
// A tick passes a check state; one that ends the interval then passes the
// grow and start states, a reset only the start state, and both then wait on
// the 16-step bit-serial remainder unit that picks the send time. When the
// span is zero the remainder is skipped; the start state sets the send time.
// A finished result sits in an output register, so the next item is taken
// while it waits. A stalled result holds the one after it until the register
// frees up. Config writes are registered and are meant for idle periods.
module trickle_interval_timer_unit
  import trk_pkg::*;
#(
  parameter int TICK_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_due,
  output logic        out_interval_restarted,
  output logic [23:0] out_interval_now,
  output logic        out_active
);

`include "trickle_interval_timer_unit_macros.svh"

  localparam int TW = TICK_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_GROW  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [15:0]   min_int_r;
  logic [3:0]    max_dbl_r;
  logic [TW-1:0] interval_len_r, interval_len_nxt;
  logic [TW-1:0] tick_count_r, tick_count_nxt;
  logic [TW-1:0] send_time_r, send_time_nxt;
  logic          armed_r, armed_nxt;
  logic          started_r, started_nxt;
  logic          restarted_r, restarted_nxt;
  logic [15:0]   rnd_r, rnd_nxt;

  logic          out_valid_r;
  logic          out_tx_due_r;
  logic          out_restarted_r;
  logic [23:0]   out_interval_r;
  logic          out_active_r;
  logic          out_load;

  logic          in_acc;
  logic [TW-1:0] min_ext;
  logic [TW-1:0] imax;
  logic [TW:0]   dbl;
  logic [TW-1:0] half;
  logic [15:0]   span;

  trk_div_req_t  div_req;
  trk_div_sts_t  div_sts;

  trk_mod_serial u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign min_ext = TW'(min_int_r);
  assign imax    = min_ext << max_dbl_r;
  assign dbl     = {interval_len_r, 1'b0};
  assign half    = interval_len_r >> 1;
  assign span    = 16'(interval_len_r - half);

  assign div_req.start    = (state_r == S_START) && (span != '0);
  assign div_req.dividend = rnd_r;
  assign div_req.divisor  = span;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt        = state_r;
    interval_len_nxt = interval_len_r;
    tick_count_nxt   = tick_count_r;
    send_time_nxt    = send_time_r;
    armed_nxt        = armed_r;
    started_nxt      = started_r;
    restarted_nxt    = restarted_r;
    rnd_nxt          = rnd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rnd_nxt       = in_random_value;
          restarted_nxt = 1'b0;
          state_nxt     = S_OUT;
          if (in_op == OP_RESET) begin
            interval_len_nxt = min_ext;
            armed_nxt        = 1'b0;
            started_nxt      = 1'b1;
            restarted_nxt    = 1'b1;
            state_nxt        = S_START;
          end else if (in_op == OP_SENT) begin
            armed_nxt = 1'b0;
          end else if (in_op == OP_TICK && started_r) begin
            tick_count_nxt = tick_count_r + 1'b1;
            state_nxt      = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (tick_count_r >= interval_len_r) begin
          restarted_nxt = 1'b1;
          state_nxt     = S_GROW;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_GROW: begin
        // double, capped at the configured maximum
        if (interval_len_r < imax) begin
          if (dbl > {1'b0, imax}) begin
            interval_len_nxt = imax;
          end else begin
            interval_len_nxt = dbl[TW-1:0];
          end
        end
        state_nxt = S_START;
      end
      S_START: begin
        if (span == '0) begin
          tick_count_nxt = '0;
          send_time_nxt  = half;
          armed_nxt      = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          tick_count_nxt = '0;
          send_time_nxt  = half + TW'(div_sts.rem);
          armed_nxt      = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rnd_r       <= rnd_nxt;
    restarted_r <= restarted_nxt;
    if (!rst_n) begin
      state_r        <= S_IDLE;
      min_int_r      <= 16'd8;
      max_dbl_r      <= 4'd4;
      interval_len_r <= '0;
      tick_count_r   <= '0;
      send_time_r    <= '0;
      armed_r        <= 1'b0;
      started_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      interval_len_r <= interval_len_nxt;
      tick_count_r   <= tick_count_nxt;
      send_time_r    <= send_time_nxt;
      armed_r        <= armed_nxt;
      started_r      <= started_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_INTERVAL:  min_int_r <= cfg_wdata;
          CFG_MAX_DOUBLINGS: max_dbl_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while the transfer is stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tx_due_r    <= armed_r && (tick_count_r >= send_time_r);
      out_restarted_r <= restarted_r;
      out_interval_r  <= 24'(interval_len_r);
      out_active_r    <= started_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_tx_due             = out_tx_due_r;
  assign out_interval_restarted = out_restarted_r;
  assign out_interval_now       = out_interval_r;
  assign out_active             = out_active_r;

  `TRK_ASSERT_NOW(a_div_done_in_div, div_sts.done, state_r == S_DIV)
  `TRK_ASSERT_NEXT(a_reset_starts, in_acc && in_op == OP_RESET, started_r)
  `TRK_ASSERT_NOW(a_armed_needs_start, armed_r, started_r)
  `TRK_ASSERT_NOW(a_due_needs_active, out_valid_r && out_tx_due_r, out_active_r)

endmodule
